FILE: hdl/cst_pkg.sv
// Shared types and constants for the coordinate set table.
`timescale 1ns / 1ps

package cst_pkg;

   // Fixed widths of the transaction fields
   localparam int FIELD_W     = 16;
   localparam int INDEX_W     = 8;
   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W    = 2;

   // Operation codes
   typedef enum logic [2:0] {
      OP_ADD        = 3'd0,
      OP_ADD_ABSENT = 3'd1,
      OP_WRITE_AT   = 3'd2,
      OP_QUERY      = 3'd3,
      OP_READ_AT    = 3'd4,
      OP_DEL_PAIR   = 3'd5,
      OP_DEL_AT     = 3'd6,
      OP_CLEAR      = 3'd7
   } opcode_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic               capture;    // register the match bit of this cell
      logic               commit;     // apply the update decided this cycle
      logic               write_at;   // overwrite the entry at idx
      logic               append;     // store the key at position count
      logic               del_first;  // remove the first matching entry
      logic               del_at;     // remove the entry at idx
      logic [INDEX_W-1:0] idx;        // position for read, write or delete
   } cell_ctl_type;

endpackage

FILE: hdl/coordinate_set_table_core.sv
// Top level of the coordinate set table: sequencer, cell row and result register.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY (x, y) pairs with content search and
// order-keeping delete. One result transaction per request transaction.
// Request channel req_*: opcode, x_in, y_in, index; taken when req_valid is
// high and req_stall is low. Result channel rsp_*: found, x_out, y_out,
// entry_count, status; taken when rsp_valid is high and rsp_stall is low.
// In the accept cycle the match bit of every cell and the addressed read
// data are registered. In the execute state, which holds while a result
// waits, the first match is resolved through the cell chain, and the commit
// updates the cells and the count and loads the result register. A new
// request is taken in the cycle after the previous one commits; the result
// appears on rsp_* the cycle after commit.
// If the receiver stalls, the result register holds; one further request
// may be taken, but it does not commit until the held result is taken.
// Synchronous reset empties the list and drops any pending result; stored
// pairs are not cleared and are never read before being written.
module coordinate_set_table_core
   import cst_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_opcode,
   input  logic signed [FIELD_W-1:0] req_x_in,
   input  logic signed [FIELD_W-1:0] req_y_in,
   input  logic [INDEX_W-1:0]        req_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic signed [FIELD_W-1:0] rsp_x_out,
   output logic signed [FIELD_W-1:0] rsp_y_out,
   output logic [COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic [STATUS_W-1:0]       rsp_status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type             state_ff;
   logic [CNT_W-1:0]      count_ff;
   opcode_type            op_ff;
   logic [COORD_BITS-1:0] key_x_ff;
   logic [COORD_BITS-1:0] key_y_ff;
   logic [INDEX_W-1:0]    idx_ff;
   logic [COORD_BITS-1:0] read_x_ff;
   logic [COORD_BITS-1:0] read_y_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [FIELD_W-1:0]    rsp_x_ff;
   logic [FIELD_W-1:0]    rsp_y_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   status_type            rsp_status_ff;

   logic                  accept;
   logic                  commit;
   logic signed [31:0]    req_x_ext;
   logic signed [31:0]    req_y_ext;
   logic signed [31:0]    read_x_ext;
   logic signed [31:0]    read_y_ext;
   logic [COORD_BITS-1:0] key_x;
   logic [COORD_BITS-1:0] key_y;
   logic [COORD_BITS-1:0] rd_x_all;
   logic [COORD_BITS-1:0] rd_y_all;
   logic                  any_hit;
   logic                  idx_ok;
   logic                  full;
   cell_ctl_type          ctl;

   logic                  found_in;
   logic [FIELD_W-1:0]    x_out_in;
   logic [FIELD_W-1:0]    y_out_in;
   logic [CNT_W-1:0]      count_in;
   status_type            status_in;

   logic [COORD_BITS-1:0] cell_x  [CAPACITY];
   logic [COORD_BITS-1:0] cell_y  [CAPACITY];
   logic [COORD_BITS-1:0] cell_rx [CAPACITY];
   logic [COORD_BITS-1:0] cell_ry [CAPACITY];
   logic [CAPACITY:0]     seen;

   // Handshake
   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // Input coordinates: sign-extend, keep the low COORD_BITS
   assign req_x_ext = 32'(req_x_in);
   assign req_y_ext = 32'(req_y_in);
   assign key_x     = (state_ff == S_IDLE) ? req_x_ext[COORD_BITS-1:0] : key_x_ff;
   assign key_y     = (state_ff == S_IDLE) ? req_y_ext[COORD_BITS-1:0] : key_y_ff;

   // Stored coordinates back to the output width
   assign read_x_ext = 32'(signed'(read_x_ff));
   assign read_y_ext = 32'(signed'(read_y_ff));

   assign any_hit = seen[CAPACITY];
   assign idx_ok  = CMP_W'(idx_ff) < CMP_W'(count_ff);
   assign full    = count_ff == CNT_W'(CAPACITY);

   // Operation decode and result
   always_comb begin
      ctl           = '0;
      ctl.capture   = accept;
      ctl.commit    = commit;
      ctl.idx       = (state_ff == S_IDLE) ? req_index : idx_ff;
      found_in      = 1'b0;
      x_out_in      = '0;
      y_out_in      = '0;
      count_in      = count_ff;
      status_in     = ST_OK;
      case (op_ff)
         OP_ADD: begin
            ctl.append = !full;
         end
         OP_ADD_ABSENT: begin
            found_in   = any_hit;
            ctl.append = !any_hit && !full;
         end
         OP_WRITE_AT: begin
            ctl.write_at = idx_ok;
            ctl.append   = !idx_ok && !full;
         end
         OP_QUERY: begin
            found_in = any_hit;
         end
         OP_READ_AT: begin
            if (idx_ok) begin
               x_out_in = read_x_ext[FIELD_W-1:0];
               y_out_in = read_y_ext[FIELD_W-1:0];
            end else begin
               x_out_in  = '1;
               y_out_in  = '1;
               status_in = ST_BAD;
            end
         end
         OP_DEL_PAIR: begin
            found_in      = any_hit;
            ctl.del_first = any_hit;
            if (any_hit) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = ST_BAD;
            end
         end
         OP_DEL_AT: begin
            ctl.del_at = idx_ok;
            if (idx_ok) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = ST_BAD;
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
      // Shared append outcome
      if ((op_ff == OP_ADD) || (op_ff == OP_ADD_ABSENT && !any_hit) ||
          (op_ff == OP_WRITE_AT && !idx_ok)) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // Read data gathered from the addressed cell
   always_comb begin
      rd_x_all = '0;
      rd_y_all = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_x_all = rd_x_all | cell_rx[i];
         rd_y_all = rd_y_all | cell_ry[i];
      end
   end

   // Row of cells, each handing its hit prefix to the next and taking the pair of the next
   assign seen[0] = 1'b0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [COORD_BITS-1:0] nxt_x;
      logic [COORD_BITS-1:0] nxt_y;

      if (g == CAPACITY - 1) begin : g_last
         assign nxt_x = cell_x[g];
         assign nxt_y = cell_y[g];
      end else begin : g_mid
         assign nxt_x = cell_x[g+1];
         assign nxt_y = cell_y[g+1];
      end

      cst_cell #(
         .CELL_IDX  (g),
         .COORD_BITS(COORD_BITS),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .count   (count_ff),
         .key_x   (key_x),
         .key_y   (key_y),
         .nxt_x   (nxt_x),
         .nxt_y   (nxt_y),
         .seen_in (seen[g]),
         .seen_out(seen[g+1]),
         .data_x  (cell_x[g]),
         .data_y  (cell_y[g]),
         .rd_x    (cell_rx[g]),
         .rd_y    (cell_ry[g])
      );
   end

   // Sequencer, list count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (commit) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         op_ff     <= opcode_type'(req_opcode);
         key_x_ff  <= key_x;
         key_y_ff  <= key_y;
         idx_ff    <= req_index;
         read_x_ff <= rd_x_all;
         read_y_ff <= rd_y_all;
      end
      if (commit) begin
         rsp_found_ff  <= found_in;
         rsp_x_ff      <= x_out_in;
         rsp_y_ff      <= y_out_in;
         rsp_count_ff  <= count_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_x_out       = rsp_x_ff;
   assign rsp_y_out       = rsp_y_ff;
   assign rsp_entry_count = COUNT_OUT_W'(rsp_count_ff);
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   // List never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // An accepted request is always executed next
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted request not executed");

   // A new result only follows an execute cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result raised without execution");

   // A dropped append is only reported while the list is full
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> full)
      else $error("full status with room in the list");

   // Found and bad status are exclusive
   a_found_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_status_ff == ST_BAD))
      else $error("found reported with bad status");
`endif

endmodule

FILE: hdl/cst_cell.sv
// One storage cell of the coordinate set table: pair, local match and shift.
`timescale 1ns / 1ps

module cst_cell
   import cst_pkg::*;
#(
   parameter int CELL_IDX   = 0,
   parameter int COORD_BITS = 16,
   parameter int CNT_W      = 7
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [CNT_W-1:0]      count,
   input  logic [COORD_BITS-1:0] key_x,
   input  logic [COORD_BITS-1:0] key_y,
   input  logic [COORD_BITS-1:0] nxt_x,
   input  logic [COORD_BITS-1:0] nxt_y,
   input  logic                  seen_in,
   output logic                  seen_out,
   output logic [COORD_BITS-1:0] data_x,
   output logic [COORD_BITS-1:0] data_y,
   output logic [COORD_BITS-1:0] rd_x,
   output logic [COORD_BITS-1:0] rd_y
);

   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic                  hit_ff;
   logic                  hit_in;
   logic                  occupied;
   logic                  at_idx;
   logic                  shift_en;
   logic                  load_en;

   // Local decode of position against count and index
   assign occupied = CNT_W'(CELL_IDX) < count;
   assign at_idx   = ctl.idx == INDEX_W'(CELL_IDX);
   assign hit_in   = occupied && (x_ff == key_x) && (y_ff == key_y);

   // Prefix of hits: set once this or an earlier cell matched
   assign seen_out = seen_in | hit_ff;

   // Close the gap: cells at or after the removed position take their neighbour
   assign shift_en = ctl.commit &&
                     ((ctl.del_first && seen_out) ||
                      (ctl.del_at && (ctl.idx <= INDEX_W'(CELL_IDX))));
   assign load_en  = ctl.commit &&
                     ((ctl.write_at && at_idx) ||
                      (ctl.append && (count == CNT_W'(CELL_IDX))));

   // Stored pair and registered match bit
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         hit_ff <= hit_in;
      end
      if (shift_en) begin
         x_ff <= nxt_x;
         y_ff <= nxt_y;
      end else if (load_en) begin
         x_ff <= key_x;
         y_ff <= key_y;
      end
   end

   assign data_x = x_ff;
   assign data_y = y_ff;

   // Read port: zero unless addressed, OR-combined upstream
   assign rd_x = at_idx ? x_ff : '0;
   assign rd_y = at_idx ? y_ff : '0;

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the coordinate set table core.
`timescale 1ns / 1ps

module testbench;
   import cst_pkg::*;

   localparam int CAP        = 64;
   localparam int ITEM_COUNT = 700;
   localparam int IDLE_LIMIT = 3000;

   // One expected result transaction
   typedef struct packed {
      logic                   found;
      logic [FIELD_W-1:0]     x_out;
      logic [FIELD_W-1:0]     y_out;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic [STATUS_W-1:0]    status;
   } table_result_type;

   // Table predictor and store of expected results
   class coord_table_scoreboard_type;
      logic [FIELD_W-1:0] pair_x[CAP];
      logic [FIELD_W-1:0] pair_y[CAP];
      int                 count;
      table_result_type   awaited[$];
      int                 fault_count;

      function new();
         count       = 0;
         fault_count = 0;
      endfunction

      // First matching position, or count when absent
      function int find_pair(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y);
         for (int i = 0; i < count; i++)
            if (pair_x[i] == x && pair_y[i] == y) return i;
         return count;
      endfunction

      function status_type append_pair(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y);
         if (count >= CAP) return ST_FULL;
         pair_x[count] = x;
         pair_y[count] = y;
         count++;
         return ST_OK;
      endfunction

      // Close the gap, keeping the order of later entries
      function void remove_at(int pos);
         for (int i = pos; i + 1 < count; i++) begin
            pair_x[i] = pair_x[i+1];
            pair_y[i] = pair_y[i+1];
         end
         count--;
      endfunction

      function void note_request(opcode_type op, logic [FIELD_W-1:0] x,
                                 logic [FIELD_W-1:0] y, logic [INDEX_W-1:0] idx);
         table_result_type r;
         int               pos;
         r.found  = 1'b0;
         r.x_out  = '0;
         r.y_out  = '0;
         r.status = ST_OK;
         case (op)
            OP_ADD: begin
               r.status = append_pair(x, y);
            end
            OP_ADD_ABSENT: begin
               if (find_pair(x, y) < count) r.found = 1'b1;
               else r.status = append_pair(x, y);
            end
            OP_WRITE_AT: begin
               if (idx < count) begin
                  pair_x[idx] = x;
                  pair_y[idx] = y;
               end else begin
                  r.status = append_pair(x, y);
               end
            end
            OP_QUERY: begin
               r.found = (find_pair(x, y) < count);
            end
            OP_READ_AT: begin
               if (idx < count) begin
                  r.x_out = pair_x[idx];
                  r.y_out = pair_y[idx];
               end else begin
                  r.x_out  = '1;
                  r.y_out  = '1;
                  r.status = ST_BAD;
               end
            end
            OP_DEL_PAIR: begin
               pos = find_pair(x, y);
               if (pos < count) begin
                  r.found = 1'b1;
                  remove_at(pos);
               end else begin
                  r.status = ST_BAD;
               end
            end
            OP_DEL_AT: begin
               if (idx < count) remove_at(idx);
               else r.status = ST_BAD;
            end
            default: begin
               count = 0;
            end
         endcase
         r.entry_count = COUNT_OUT_W'(count);
         awaited.insert(awaited.size(), r);
      endfunction

      function void check_result(table_result_type got);
         table_result_type want;
         if (awaited.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: unexpected result: found=%0b x=%0d y=%0d count=%0d status=%0d",
                        $realtime, got.found, $signed(got.x_out), $signed(got.y_out),
                        got.entry_count, got.status);
            return;
         end
         want = awaited.pop_front();
         if (got.found !== want.found || got.x_out !== want.x_out ||
             got.y_out !== want.y_out || got.entry_count !== want.entry_count ||
             got.status !== want.status) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("%0t: mismatch, expected found=%0b x=%0d y=%0d count=%0d status=%0d",
                        $realtime, want.found, $signed(want.x_out), $signed(want.y_out),
                        want.entry_count, want.status);
               $display("%0t: mismatch, actual   found=%0b x=%0d y=%0d count=%0d status=%0d",
                        $realtime, got.found, $signed(got.x_out), $signed(got.y_out),
                        got.entry_count, got.status);
            end
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [2:0]                req_opcode = OP_QUERY;
   logic signed [FIELD_W-1:0] req_x_in = '0;
   logic signed [FIELD_W-1:0] req_y_in = '0;
   logic [INDEX_W-1:0]        req_index = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_found;
   logic signed [FIELD_W-1:0] rsp_x_out;
   logic signed [FIELD_W-1:0] rsp_y_out;
   logic [COUNT_OUT_W-1:0]    rsp_entry_count;
   logic [STATUS_W-1:0]       rsp_status;

   coord_table_scoreboard_type table_sb = new();

   coordinate_set_table_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_x_in        (req_x_in),
      .req_y_in        (req_y_in),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_x_out       (rsp_x_out),
      .rsp_y_out       (rsp_y_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Result monitor: values seen here are those before the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         table_sb.check_result({rsp_found, rsp_x_out, rsp_y_out, rsp_entry_count, rsp_status});
   end

   // Receiver stall pattern, chosen at random among four modes
   int stall_mode  = 0;
   int stall_phase = 0;
   int stall_hold  = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_phase == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_phase = 50;
         end
         stall_phase--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 6);
            default: begin
               // long stretches of stall and release
               if (stall_hold == 0) begin
                  stall_hold = $urandom_range(1, 12);
                  rsp_stall <= ~rsp_stall;
               end
               stall_hold--;
            end
         endcase
      end
   end

   // Watchdog on cycles with no transaction on either side
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Present one request and hold it until taken
   task automatic send_item(opcode_type op, logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                            logic [INDEX_W-1:0] idx);
      req_opcode <= op;
      req_x_in   <= x;
      req_y_in   <= y;
      req_index  <= idx;
      req_valid  <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      table_sb.note_request(op, x, y, idx);
   endtask

   task automatic hold_off(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (table_sb.awaited.size() > 0) @(posedge clock);
   endtask

   // Cumulative opcode weights for the grow, mixed and shrink phases
   function automatic opcode_type pick_op(int phase);
      int unsigned cuts[3][7] = '{'{35, 55, 65, 73, 83, 91, 100},
                                  '{16, 28, 40, 53, 67, 81, 98},
                                  '{5, 10, 15, 25, 35, 65, 99}};
      int unsigned r;
      r = $urandom_range(0, 99);
      for (int i = 0; i < 7; i++)
         if (r < cuts[phase][i]) return opcode_type'(i);
      return OP_CLEAR;
   endfunction

   // Mostly a small set of values so that pairs collide
   function automatic logic [FIELD_W-1:0] pick_coord();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return FIELD_W'($urandom_range(0, 6)) - FIELD_W'(3);
      if (r < 55) begin
         case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'h0000;
         endcase
      end
      return FIELD_W'($urandom);
   endfunction

   task automatic send_random(int phase);
      opcode_type         op;
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic [INDEX_W-1:0] idx;
      int                 pick;
      op = pick_op(phase);
      x  = pick_coord();
      y  = pick_coord();
      // often reuse a stored pair so that searches hit
      if (table_sb.count > 0 && $urandom_range(0, 99) < 35) begin
         pick = $urandom_range(0, table_sb.count - 1);
         x    = table_sb.pair_x[pick];
         y    = table_sb.pair_y[pick];
      end
      if ($urandom_range(0, 9) < 7) idx = INDEX_W'($urandom_range(0, table_sb.count + 1));
      else idx = INDEX_W'($urandom_range(0, 255));
      send_item(op, x, y, idx);
   endtask

   // Stimulus
   initial begin
      int sent;
      int burst;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, extremes, present and absent pairs, bad indexes
      send_item(OP_CLEAR,      16'h0000, 16'h0000, 8'd0);
      send_item(OP_READ_AT,    16'h0000, 16'h0000, 8'd0);
      send_item(OP_DEL_PAIR,   16'h0001, 16'h0001, 8'd0);
      send_item(OP_DEL_AT,     16'h0000, 16'h0000, 8'd0);
      send_item(OP_ADD,        16'h8000, 16'h7FFF, 8'd0);
      send_item(OP_ADD,        16'h7FFF, 16'h8000, 8'd0);
      send_item(OP_ADD_ABSENT, 16'h7FFF, 16'h8000, 8'd0);
      send_item(OP_ADD_ABSENT, 16'h0000, 16'h0000, 8'd0);
      send_item(OP_QUERY,      16'h0000, 16'h0000, 8'd0);
      send_item(OP_QUERY,      16'h0005, 16'h0005, 8'd0);
      send_item(OP_WRITE_AT,   16'hFFFF, 16'hFFFF, 8'd1);
      send_item(OP_WRITE_AT,   16'h04D2, 16'hFB2E, 8'd200);
      send_item(OP_READ_AT,    16'h0000, 16'h0000, 8'd0);
      send_item(OP_READ_AT,    16'h0000, 16'h0000, 8'd1);
      send_item(OP_READ_AT,    16'h0000, 16'h0000, 8'd3);
      send_item(OP_READ_AT,    16'hFFFF, 16'hFFFF, 8'd255);
      send_item(OP_ADD,        16'h0000, 16'h0000, 8'd0);
      send_item(OP_DEL_PAIR,   16'h0000, 16'h0000, 8'd0);
      send_item(OP_QUERY,      16'h0000, 16'h0000, 8'd0);
      send_item(OP_DEL_AT,     16'h0000, 16'h0000, 8'd0);
      send_item(OP_DEL_AT,     16'h0000, 16'h0000, 8'd255);
      send_item(OP_READ_AT,    16'h0000, 16'h0000, 8'd0);
      send_item(OP_CLEAR,      16'hFFFF, 16'hFFFF, 8'd255);
      send_item(OP_READ_AT,    16'h0000, 16'h0000, 8'd0);
      drain();

      // Random: grow, mixed and shrink phases of 100 transactions each
      sent = 0;
      while (sent < ITEM_COUNT) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 16);
         for (int k = 0; k < burst && sent < ITEM_COUNT; k++) begin
            send_random((sent / 100) % 3);
            sent++;
         end
         if (sent % 150 < burst) drain();
         else if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
      end

      // Let the pipeline empty, then judge
      drain();
      repeat (10) @(posedge clock);
      table_sb.fault_count += table_sb.awaited.size();
      if (table_sb.fault_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
